>>> hdl/iirf_pkg.sv
`timescale 1ns / 1ps

package iirf_pkg;

   // filter order (1 or 2) and sample width
   localparam int ORDER      = 2;
   localparam int SAMPLE_W   = 24;

   // fixed-point formats
   localparam int COEF_W     = 24;
   localparam int STATE_W    = 48;
   localparam int FRAC_BITS  = 22;
   localparam int PROD_W     = COEF_W + SAMPLE_W;
   localparam int ACC_W      = ((PROD_W > STATE_W) ? PROD_W : STATE_W) + 2;

   // configuration port
   localparam int NUM_REGS   = 7;
   localparam int CSR_IDX_W  = $clog2(NUM_REGS);
   localparam int CSR_DATA_W = STATE_W;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_B0     = CSR_IDX_W'(0),
      REG_COEF_B1     = CSR_IDX_W'(1),
      REG_COEF_B2     = CSR_IDX_W'(2),
      REG_COEF_A1     = CSR_IDX_W'(3),
      REG_COEF_A2     = CSR_IDX_W'(4),
      REG_INIT_STATE0 = CSR_IDX_W'(5),
      REG_INIT_STATE1 = CSR_IDX_W'(6)
   } csr_index_type;

   // payloads
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       restart;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       clipped;
   } rsp_type;

   // multiplier operand selection
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_B0_IN,
      MUL_B1_X,
      MUL_B2_X,
      MUL_A1_Y,
      MUL_A2_Y
   } mul_sel_type;

   // accumulator operation
   typedef enum logic [1:0] {
      ACC_KEEP,
      ACC_ROUND_S0,
      ACC_PROD_S1,
      ACC_FROM_HOLD
   } acc_op_type;

   // controller to datapath commands
   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        y_en;
      logic        hold_en;
      logic        s0_wr;
      logic        s1_wr;
      logic        out_en;
   } cmd_type;

endpackage

>>> hdl/iirf_ctrl.sv
`timescale 1ns / 1ps

module iirf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output iirf_pkg::cmd_type cmd
);
   import iirf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC0,
      S_YS,
      S_M1,
      S_W0,
      S_W1
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      slot_free;

   // result register can take a new value
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // command decode and next state
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_NONE;
      cmd.acc_op  = ACC_KEEP;
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.mul_sel = MUL_B0_IN;
               state_in    = S_ACC0;
            end
         end
         S_ACC0: begin
            cmd.acc_op  = ACC_ROUND_S0;
            cmd.mul_sel = MUL_B1_X;
            state_in    = S_YS;
         end
         S_YS: begin
            cmd.y_en    = 1'b1;
            cmd.acc_op  = ACC_PROD_S1;
            cmd.mul_sel = MUL_B2_X;
            state_in    = S_M1;
         end
         S_M1: begin
            cmd.hold_en = 1'b1;
            cmd.mul_sel = MUL_A1_Y;
            state_in    = S_W0;
         end
         S_W0: begin
            cmd.s0_wr   = 1'b1;
            cmd.acc_op  = ACC_FROM_HOLD;
            cmd.mul_sel = MUL_A2_Y;
            state_in    = S_W1;
         end
         S_W1: begin
            // wait here while the previous result is still pending
            if (slot_free) begin
               cmd.s1_wr  = 1'b1;
               cmd.out_en = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/iirf_datapath.sv
`timescale 1ns / 1ps

module iirf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  iirf_pkg::req_type                   req_data,
   input  iirf_pkg::cmd_type                   cmd,
   input  logic                                csr_we,
   input  logic [iirf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [iirf_pkg::CSR_DATA_W-1:0]     csr_data,
   output iirf_pkg::rsp_type                   rsp_data
);
   import iirf_pkg::*;

   localparam logic [COEF_W-1:0] B0_RESET = COEF_W'(64'd1 << FRAC_BITS);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] ST_HI =
      {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ST_LO =
      {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] Y_HI =
      {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] Y_LO =
      {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   // configuration registers
   logic signed [COEF_W-1:0]   b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [STATE_W-1:0]  init0_ff, init1_ff;

   // working registers
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   hold_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [STATE_W-1:0]  s0_ff, s1_ff;
   logic signed [STATE_W-1:0]  state_in;
   logic signed [SAMPLE_W-1:0] y_ff;
   logic signed [SAMPLE_W-1:0] y_in;
   logic                       clip_ff;
   logic                       clip_in;
   rsp_type                    rsp_data_ff;

   logic signed [COEF_W-1:0]   coef_m;
   logic signed [SAMPLE_W-1:0] opnd_m;
   logic signed [ACC_W-1:0]    diff;
   logic signed [ACC_W-1:0]    quot;

   // configuration writes, out-of-range index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff    <= B0_RESET;
         b1_ff    <= '0;
         b2_ff    <= '0;
         a1_ff    <= '0;
         a2_ff    <= '0;
         init0_ff <= '0;
         init1_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_COEF_B0:     b0_ff    <= csr_data[COEF_W-1:0];
            REG_COEF_B1:     b1_ff    <= csr_data[COEF_W-1:0];
            REG_COEF_B2:     b2_ff    <= csr_data[COEF_W-1:0];
            REG_COEF_A1:     a1_ff    <= csr_data[COEF_W-1:0];
            REG_COEF_A2:     a2_ff    <= csr_data[COEF_W-1:0];
            REG_INIT_STATE0: init0_ff <= csr_data[STATE_W-1:0];
            REG_INIT_STATE1: init1_ff <= csr_data[STATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_B0_IN: begin
            coef_m = b0_ff;
            opnd_m = req_data.sample;
         end
         MUL_B1_X: begin
            coef_m = b1_ff;
            opnd_m = x_ff;
         end
         MUL_B2_X: begin
            coef_m = b2_ff;
            opnd_m = x_ff;
         end
         MUL_A1_Y: begin
            coef_m = a1_ff;
            opnd_m = y_ff;
         end
         MUL_A2_Y: begin
            coef_m = a2_ff;
            opnd_m = y_ff;
         end
         default: begin
            coef_m = b0_ff;
            opnd_m = x_ff;
         end
      endcase
   end

   assign prod_in = coef_m * opnd_m;

   // accumulator
   always_comb begin
      case (cmd.acc_op)
         ACC_ROUND_S0:  acc_in = ACC_W'(prod_ff) + ACC_W'(s0_ff) + ROUND_HALF;
         ACC_PROD_S1:   acc_in = ACC_W'(prod_ff) + ACC_W'(s1_ff);
         ACC_FROM_HOLD: acc_in = ACC_W'(hold_ff);
         default:       acc_in = acc_ff;
      endcase
   end

   // new delay value: accumulated terms minus feedback product, saturated
   assign diff = acc_ff - ACC_W'(prod_ff);

   always_comb begin
      if (diff > ST_HI) begin
         state_in = ST_HI[STATE_W-1:0];
      end else if (diff < ST_LO) begin
         state_in = ST_LO[STATE_W-1:0];
      end else begin
         state_in = diff[STATE_W-1:0];
      end
   end

   // output sample: floor of the half-biased accumulator, saturated
   assign quot = acc_ff >>> FRAC_BITS;

   always_comb begin
      clip_in = 1'b1;
      if (quot > Y_HI) begin
         y_in = Y_HI[SAMPLE_W-1:0];
      end else if (quot < Y_LO) begin
         y_in = Y_LO[SAMPLE_W-1:0];
      end else begin
         y_in    = quot[SAMPLE_W-1:0];
         clip_in = 1'b0;
      end
   end

   // delay state
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff <= '0;
         s1_ff <= '0;
      end else begin
         if (cmd.load && req_data.restart) begin
            s0_ff <= init0_ff;
            s1_ff <= (ORDER >= 2) ? init1_ff : '0;
         end
         if (cmd.s0_wr) begin
            s0_ff <= state_in;
         end
         if (cmd.s1_wr && (ORDER >= 2)) begin
            s1_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_data.sample;
      end
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (cmd.hold_en) begin
         hold_ff <= prod_ff;
      end
      acc_ff <= acc_in;
      if (cmd.y_en) begin
         y_ff    <= y_in;
         clip_ff <= clip_in;
      end
      if (cmd.out_en) begin
         rsp_data_ff.filtered <= y_ff;
         rsp_data_ff.clipped  <= clip_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

>>> hdl/iir_filter_second_order.sv
`timescale 1ns / 1ps
// One sample at a time: req_stall stays high until its result is published, which
// waits while an earlier result is stalled. The single shared 24x24 multiplier forms
// the five products in sequence, then the delay state is written back.
// Reset (synchronous, active high): coefficients return to b0 = 1.0 and all others 0,
// initial-condition registers and delay state clear to 0, no result pending.
module iir_filter_second_order (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  iirf_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output iirf_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [iirf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [iirf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import iirf_pkg::*;

   cmd_type cmd;

   // register writes are always taken
   assign csr_ready = 1'b1;

   iirf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   iirf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

   // busy right after a transaction is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted twice in a row");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_en |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");

   // a taken result is not repeated
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !cmd.out_en) |=> !rsp_valid)
      else $error("result transaction repeated");

   // load, state writeback and publish fall in distinct steps
   a_steps_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.s0_wr, cmd.out_en}))
      else $error("overlapping datapath commands");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import iirf_pkg::*;

   // kinds of register settings used by the random phases
   typedef enum int {
      SET_RANDOM,
      SET_EXTREME,
      SET_STABLE
   } setting_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // stimulus and expected outputs
   req_type sample_queue[$];
   rsp_type expected_outputs[$];
   rsp_type oldest_output;

   // filter copy: coefficients, initial conditions and delay line
   logic [COEF_W-1:0]  coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
   logic [STATE_W-1:0] init_state0, init_state1;
   longint             delay0, delay1;

   int   mismatch_count = 0;
   int   req_gap        = 0;
   int   stall_left     = 0;
   logic req_taken      = 1'b0;
   logic steady_mode    = 1'b0;

   iir_filter_second_order i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // clamp to a signed range of w bits, flag when clamped
   function automatic longint saturate(input longint v, input int w, output logic hit);
      longint hi, lo;
      hi  = (longint'(1) <<< (w - 1)) - 1;
      lo  = -hi - 1;
      hit = 1'b0;
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // one sample through the transposed direct form II section
   function automatic rsp_type filter_sample(input req_type item);
      longint  x, b0, b1, b2, a1, a2, acc, y;
      logic    clip, state_hit;
      rsp_type result;
      x  = longint'($signed(item.sample));
      b0 = longint'($signed(coef_b0));
      b1 = longint'($signed(coef_b1));
      b2 = longint'($signed(coef_b2));
      a1 = longint'($signed(coef_a1));
      a2 = longint'($signed(coef_a2));
      if (item.restart) begin
         delay0 = longint'($signed(init_state0));
         delay1 = (ORDER >= 2) ? longint'($signed(init_state1)) : 0;
      end
      // round half up, then clamp to the sample range
      acc = b0 * x + delay0;
      y   = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      y   = saturate(y, SAMPLE_W, clip);
      // feedback uses the delivered output
      if (ORDER >= 2) begin
         delay0 = saturate(b1 * x - a1 * y + delay1, STATE_W, state_hit);
         delay1 = saturate(b2 * x - a2 * y, STATE_W, state_hit);
      end else begin
         delay0 = saturate(b1 * x - a1 * y, STATE_W, state_hit);
         delay1 = 0;
      end
      result.filtered = SAMPLE_W'(y);
      result.clipped  = clip;
      return result;
   endfunction

   // input driver: next transaction or idle gap at each falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (sample_queue.size() > 0) begin
            req_data  <= sample_queue.pop_front();
            req_valid <= 1'b1;
            if (!steady_mode && $urandom_range(3) == 0) begin
               req_gap <= $urandom_range(19, 1);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // output back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!steady_mode && $urandom_range(7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(18, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // register writes, input transactions and result checks at the rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (reset) begin
         coef_b0     = COEF_W'(4194304);
         coef_b1     = '0;
         coef_b2     = '0;
         coef_a1     = '0;
         coef_a2     = '0;
         init_state0 = '0;
         init_state1 = '0;
         delay0      = 0;
         delay1      = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_COEF_B0:     coef_b0     = csr_data[COEF_W-1:0];
               REG_COEF_B1:     coef_b1     = csr_data[COEF_W-1:0];
               REG_COEF_B2:     coef_b2     = csr_data[COEF_W-1:0];
               REG_COEF_A1:     coef_a1     = csr_data[COEF_W-1:0];
               REG_COEF_A2:     coef_a2     = csr_data[COEF_W-1:0];
               REG_INIT_STATE0: init_state0 = csr_data[STATE_W-1:0];
               REG_INIT_STATE1: init_state1 = csr_data[STATE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_outputs.insert(expected_outputs.size(), filter_sample(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               $error("unexpected result transaction: filtered=%0d clipped=%0b",
                      rsp_data.filtered, rsp_data.clipped);
               mismatch_count++;
            end else begin
               oldest_output = expected_outputs.pop_front();
               if (rsp_data.filtered !== oldest_output.filtered) begin
                  $error("filtered: expected %0d, actual %0d",
                         oldest_output.filtered, rsp_data.filtered);
                  mismatch_count++;
               end
               if (rsp_data.clipped !== oldest_output.clipped) begin
                  $error("clipped: expected %0b, actual %0b",
                         oldest_output.clipped, rsp_data.clipped);
                  mismatch_count++;
               end
            end
         end
      end
   end

   task automatic queue_sample(input logic [SAMPLE_W-1:0] value, input logic restart);
      req_type item;
      item.sample  = value;
      item.restart = restart;
      sample_queue.insert(sample_queue.size(), item);
   endtask

   task automatic write_reg(input int idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every queued transaction has come back
   task automatic drain;
      while (sample_queue.size() != 0 || req_valid || expected_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   initial begin
      setting_kind_type  kind;
      int                count, pick;
      logic [63:0]       r;
      logic [CSR_DATA_W-1:0] value;
      logic [SAMPLE_W-1:0]   s;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficients: unity pass-through, extremes and a restart
      queue_sample(24'h000000, 1'b0);
      queue_sample(24'h7FFFFF, 1'b0);
      queue_sample(24'h800000, 1'b0);
      queue_sample(24'h000001, 1'b0);
      queue_sample(24'hFFFFFF, 1'b1);
      queue_sample(24'h003039, 1'b0);
      drain();

      // half gain: ties round toward plus infinity; bad index is ignored
      write_reg(REG_COEF_B0, 48'h000000_200000);
      write_reg(NUM_REGS, 48'hFFFF_FFFF_FFFF);
      queue_sample(24'h000001, 1'b0);
      queue_sample(24'hFFFFFF, 1'b0);
      queue_sample(24'h000003, 1'b0);
      queue_sample(24'hFFFFFD, 1'b0);
      drain();

      // full-scale coefficients and initial states: clipping and state saturation
      write_reg(REG_COEF_B0, 48'h000000_7FFFFF);
      write_reg(REG_COEF_B1, 48'h000000_7FFFFF);
      write_reg(REG_COEF_B2, 48'h000000_800000);
      write_reg(REG_COEF_A1, 48'h000000_800000);
      write_reg(REG_COEF_A2, 48'h000000_7FFFFF);
      write_reg(REG_INIT_STATE0, 48'h7FFF_FFFF_FFFF);
      write_reg(REG_INIT_STATE1, 48'h8000_0000_0000);
      queue_sample(24'h7FFFFF, 1'b1);
      queue_sample(24'h800000, 1'b0);
      queue_sample(24'h7FFFFF, 1'b0);
      queue_sample(24'h000000, 1'b1);
      queue_sample(24'h000000, 1'b0);
      drain();

      // most negative gain, upper data bits above the coefficient width set
      write_reg(REG_COEF_B0, 48'hABCDEF_800000);
      queue_sample(24'h800000, 1'b1);
      queue_sample(24'h7FFFFF, 1'b0);
      drain();

      // random phases, the last two without idling
      for (int phase = 0; phase < 12; phase++) begin
         kind = setting_kind_type'(phase % 3);
         if (phase >= 10) steady_mode = 1'b1;
         for (int idx = 0; idx < NUM_REGS; idx++) begin
            r = {$urandom(), $urandom()};
            case (kind)
               SET_RANDOM: value = r[CSR_DATA_W-1:0];
               SET_EXTREME: begin
                  pick = $urandom_range(3);
                  if (idx < int'(REG_INIT_STATE0)) begin
                     value = (pick == 0) ? 48'h7FFFFF : (pick == 1) ? 48'h800000 :
                             (pick == 2) ? 48'h000000 : 48'h400000;
                  end else begin
                     value = (pick == 0) ? 48'h7FFF_FFFF_FFFF :
                             (pick == 1) ? 48'h8000_0000_0000 :
                             (pick == 2) ? 48'h0 : 48'hFFFF_FFFF_FFFF;
                  end
               end
               default: begin
                  // bounded feedback coefficients keep the filter stable
                  case (csr_index_type'(idx))
                     REG_COEF_A2:
                        value = 48'(int'($urandom_range(3355442)) - 1677721);
                     REG_INIT_STATE0, REG_INIT_STATE1:
                        value = 48'($signed(r[40:0]));
                     default:
                        value = 48'(int'($urandom_range(4194304)) - 2097152);
                  endcase
               end
            endcase
            write_reg(idx, value);
         end
         if ($urandom_range(3) == 0) write_reg(NUM_REGS, r[CSR_DATA_W-1:0]);

         count = $urandom_range(135, 90);
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(15);
            if (pick == 0) s = 24'h7FFFFF;
            else if (pick == 1) s = 24'h800000;
            else if (pick == 2) s = SAMPLE_W'(int'($urandom_range(2)) - 1);
            else if (pick < 7) s = SAMPLE_W'(int'($urandom_range(2000)) - 1000);
            else s = SAMPLE_W'($urandom());
            queue_sample(s, ($urandom_range(15) == 0) || (n == 0 && $urandom_range(1) == 1));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[iir_filter_second_order] OK");
      end else begin
         $display("[iir_filter_second_order] ERROR");
      end
      $finish;
   end

   // overall run limit
   initial begin
      #2000000;
      $display("[iir_filter_second_order] ERROR");
      $finish;
   end

endmodule
